[src/iprm_pkg.sv]
// Shared types and constants for the inverse page range map insert block.
package iprm_pkg;

    localparam int ENTRIES    = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int USED_W     = IDX_W + 1;

    localparam logic [1:0] STAT_FIRST  = 2'd0;
    localparam logic [1:0] STAT_JOINED = 2'd1;
    localparam logic [1:0] STAT_APPEND = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    localparam logic [32:0] CNT_MAX = 33'h0_FFFF_FFFF;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_WRITE,
        BK_OUT
    } bk_state_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic [63:0] phys;
        logic [63:0] virt;
        logic [31:0] pages;
        logic [63:0] npn;
        logic [63:0] off;
    } item_t;

    // Status from the back end that the top level watches.
    typedef struct packed {
        logic [USED_W-1:0] used;
        logic              busy;
    } bk_stat_t;

endpackage

[src/iprm_if.sv]
// Handshake interfaces for the request and result channels.
interface iprm_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] phys_addr;
    logic [63:0] virt_addr;
    logic [31:0] page_count;

    modport source (output valid, phys_addr, virt_addr, page_count, input ready);
    modport sink   (input valid, phys_addr, virt_addr, page_count, output ready);
endinterface

interface iprm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [63:0] entry_phys;
    logic [63:0] entry_virt;
    logic [31:0] entry_pages;

    modport source (output valid, status, entry_index, entry_phys, entry_virt, entry_pages,
                    input ready);
    modport sink   (input valid, status, entry_index, entry_phys, entry_virt, entry_pages,
                    output ready);
endinterface

[src/inverse_page_range_map_insert.sv]
// Top level of the inverse page range map insert block.
// An insert scans the entries in use, one table read per cycle on the single read port, then
// writes the entry unless the table is full, and returns the result beat; the first insert
// skips the scan. One insert is handled at a time. Two request beats can queue ahead of the
// scan.
// Reset clears the entry count and the queue; the table contents are left as they are.
module inverse_page_range_map_insert
    import iprm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    iprm_req_if.sink   req,
    iprm_rsp_if.source rsp
);

    logic     q_valid;
    logic     q_ready;
    item_t    q_item;
    bk_stat_t stat;

    iprm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    iprm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .rsp     (rsp),
        .stat    (stat)
    );

    // The entry count never passes the table size.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used <= USED_W'(ENTRIES))
        else $error("entry count exceeds table size");

    // A full result only appears when every entry is in use.
    a_full_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == STAT_FULL |-> stat.used == USED_W'(ENTRIES))
        else $error("full status with free entries");

    // The entry count only ever grows by one.
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used != $past(stat.used) |-> stat.used == $past(stat.used) + 1'b1)
        else $error("entry count changed by other than one");

    // A result beat is never shown while the back end is idle.
    a_rsp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> stat.busy)
        else $error("result beat while idle");

endmodule

[src/iprm_front.sv]
// Front end: accepts request beats, computes page numbers and offset, queues them.
module iprm_front
    import iprm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    iprm_req_if.sink   req,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_ready
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    item_t       in_item;
    logic        push;
    logic        pop;

    // Classify the incoming beat.
    always_comb
    begin
        in_item.phys  = req.phys_addr;
        in_item.virt  = req.virt_addr;
        in_item.pages = req.page_count;
        in_item.npn   = req.phys_addr >> PAGE_SHIFT;
        in_item.off   = (req.virt_addr >> PAGE_SHIFT) - (req.phys_addr >> PAGE_SHIFT);
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = slot_reg[rd_ptr_reg];

    // Two-entry queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[src/iprm_back.sv]
// Back end: scans the range table, joins or appends, and returns the result beat.
module iprm_back
    import iprm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  item_t      q_item,
    output logic       q_ready,
    iprm_rsp_if.source rsp,
    output bk_stat_t   stat
);

    logic [63:0] mem_phys  [ENTRIES];
    logic [63:0] mem_virt  [ENTRIES];
    logic [31:0] mem_pages [ENTRIES];

    bk_state_t         state_reg, state_next;
    item_t             item_reg, item_next;
    logic [USED_W-1:0] idx_reg, idx_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic              chk_v_reg, chk_v_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]  w_idx_reg, w_idx_next;
    logic [63:0]       w_phys_reg, w_phys_next;
    logic [63:0]       w_virt_reg, w_virt_next;
    logic [31:0]       w_pages_reg, w_pages_next;
    logic [1:0]        w_stat_reg, w_stat_next;
    logic [63:0]       rd_phys_reg;
    logic [63:0]       rd_virt_reg;
    logic [31:0]       rd_pages_reg;

    logic        issue;
    logic        mem_we;
    logic [63:0] epn;
    logic [63:0] eoff;
    logic        lower;
    logic [63:0] d;
    logic        join_ok;
    logic [32:0] n_sum;
    logic [32:0] n_max;
    logic [31:0] n_sat;

    // Compare the entry read last cycle against the pending request.
    always_comb
    begin
        epn   = rd_phys_reg >> PAGE_SHIFT;
        eoff  = (rd_virt_reg >> PAGE_SHIFT) - epn;
        lower = item_reg.phys < rd_phys_reg;
        if (lower)
        begin
            d       = epn - item_reg.npn;
            join_ok = (eoff == item_reg.off) && (d <= {32'd0, item_reg.pages});
            n_sum   = {1'b0, rd_pages_reg} + {1'b0, d[31:0]};
            n_max   = ({1'b0, item_reg.pages} > n_sum) ? {1'b0, item_reg.pages} : n_sum;
        end
        else
        begin
            d       = item_reg.npn - epn;
            join_ok = (eoff == item_reg.off) && (d <= {32'd0, rd_pages_reg});
            n_sum   = {1'b0, item_reg.pages} + {1'b0, d[31:0]};
            n_max   = ({1'b0, rd_pages_reg} > n_sum) ? {1'b0, rd_pages_reg} : n_sum;
        end
        n_sat = (n_max > CNT_MAX) ? 32'hFFFF_FFFF : n_max[31:0];
    end

    assign issue = (idx_reg < used_reg) && !(chk_v_reg && join_ok);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (used_reg == '0) ? BK_WRITE : BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (chk_v_reg && join_ok)
                begin
                    state_next = BK_WRITE;
                end
                else if (!issue && !chk_v_reg)
                begin
                    state_next = (used_reg == USED_W'(ENTRIES)) ? BK_OUT : BK_WRITE;
                end
            end
            BK_WRITE:
            begin
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath updates for each state.
    always_comb
    begin
        item_next    = item_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        chk_v_next   = 1'b0;
        chk_idx_next = chk_idx_reg;
        w_idx_next   = w_idx_reg;
        w_phys_next  = w_phys_reg;
        w_virt_next  = w_virt_reg;
        w_pages_next = w_pages_reg;
        w_stat_next  = w_stat_reg;
        mem_we       = 1'b0;
        q_ready      = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_ready      = 1'b1;
                item_next    = q_item;
                idx_next     = '0;
                w_idx_next   = '0;
                w_phys_next  = q_item.phys;
                w_virt_next  = q_item.virt;
                w_pages_next = q_item.pages;
                w_stat_next  = STAT_FIRST;
            end
            BK_SCAN:
            begin
                if (chk_v_reg && join_ok)
                begin
                    w_idx_next   = chk_idx_reg;
                    w_phys_next  = lower ? item_reg.phys : rd_phys_reg;
                    w_virt_next  = lower ? item_reg.virt : rd_virt_reg;
                    w_pages_next = n_sat;
                    w_stat_next  = STAT_JOINED;
                end
                else if (issue)
                begin
                    chk_v_next   = 1'b1;
                    chk_idx_next = idx_reg[IDX_W-1:0];
                    idx_next     = idx_reg + 1'b1;
                end
                else if (!chk_v_reg)
                begin
                    if (used_reg == USED_W'(ENTRIES))
                    begin
                        w_idx_next   = '0;
                        w_phys_next  = '0;
                        w_virt_next  = '0;
                        w_pages_next = '0;
                        w_stat_next  = STAT_FULL;
                    end
                    else
                    begin
                        w_idx_next   = used_reg[IDX_W-1:0];
                        w_phys_next  = item_reg.phys;
                        w_virt_next  = item_reg.virt;
                        w_pages_next = item_reg.pages;
                        w_stat_next  = STAT_APPEND;
                    end
                end
            end
            BK_WRITE:
            begin
                mem_we = 1'b1;
                if (w_stat_reg != STAT_JOINED)
                begin
                    used_next = used_reg + 1'b1;
                end
            end
            BK_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Range table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_phys[w_idx_reg]  <= w_phys_reg;
            mem_virt[w_idx_reg]  <= w_virt_reg;
            mem_pages[w_idx_reg] <= w_pages_reg;
        end
        if (state_reg == BK_SCAN && issue)
        begin
            rd_phys_reg  <= mem_phys[idx_reg[IDX_W-1:0]];
            rd_virt_reg  <= mem_virt[idx_reg[IDX_W-1:0]];
            rd_pages_reg <= mem_pages[idx_reg[IDX_W-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        w_idx_reg   <= w_idx_next;
        w_phys_reg  <= w_phys_next;
        w_virt_reg  <= w_virt_next;
        w_pages_reg <= w_pages_next;
        w_stat_reg  <= w_stat_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            used_reg  <= '0;
            chk_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            chk_v_reg <= chk_v_next;
        end
    end

    // Result beat.
    assign rsp.valid       = (state_reg == BK_OUT);
    assign rsp.status      = w_stat_reg;
    assign rsp.entry_index = 6'(w_idx_reg);
    assign rsp.entry_phys  = w_phys_reg;
    assign rsp.entry_virt  = w_virt_reg;
    assign rsp.entry_pages = w_pages_reg;

    assign stat.used = used_reg;
    assign stat.busy = (state_reg != BK_IDLE);

endmodule

[sim/tb_inverse_page_range_map_insert.sv]
// Self-checking testbench for the inverse page range map insert block.
module tb_inverse_page_range_map_insert;
    import iprm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [63:0] phys;
        logic [63:0] virt;
        logic [31:0] pages;
    } range_t;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [63:0] phys;
        logic [63:0] virt;
        logic [31:0] pages;
    } outcome_t;

    logic clk;
    logic rst_n;

    iprm_req_if req_ch ();
    iprm_rsp_if rsp_ch ();

    inverse_page_range_map_insert u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Items waiting to be sent and outcomes waiting to be seen.
    range_t   pending_ranges[$];
    outcome_t expected_outcomes[$];
    // History of generated ranges, used to craft ranges that join.
    range_t   sent_history[$];

    // Predicted table state.
    logic [63:0] map_phys[ENTRIES];
    logic [63:0] map_virt[ENTRIES];
    logic [31:0] map_pages[ENTRIES];
    int          map_used = 0;

    int send_idle_pct;
    int recv_stall_pct;
    bit recv_hold;
    int mismatches = 0;
    int checked = 0;
    int joins_seen = 0;
    int full_seen = 0;
    int cycles = 0;

    // Predict one insert and update the table copy.
    function automatic outcome_t predict_insert(range_t r);
        outcome_t    o;
        logic [63:0] npn;
        logic [63:0] noff;
        logic [63:0] epn;
        logic [63:0] d;
        logic [64:0] n;
        npn  = r.phys >> PAGE_SHIFT;
        noff = (r.virt >> PAGE_SHIFT) - npn;
        if (map_used == 0) begin
            map_phys[0]  = r.phys;
            map_virt[0]  = r.virt;
            map_pages[0] = r.pages;
            map_used     = 1;
            o = '{STAT_FIRST, 6'd0, r.phys, r.virt, r.pages};
            return o;
        end
        for (int i = 0; i < map_used; i++) begin
            epn = map_phys[i] >> PAGE_SHIFT;
            if ((map_virt[i] >> PAGE_SHIFT) - epn != noff)
                continue;
            if (r.phys < map_phys[i]) begin
                d = epn - npn;
                if (d > {32'd0, r.pages})
                    continue;
                n = {33'd0, map_pages[i]} + {1'b0, d};
                if ({33'd0, r.pages} > n)
                    n = {33'd0, r.pages};
                map_phys[i] = r.phys;
                map_virt[i] = r.virt;
            end
            else begin
                d = npn - epn;
                if (d > {32'd0, map_pages[i]})
                    continue;
                n = {33'd0, r.pages} + {1'b0, d};
                if ({33'd0, map_pages[i]} > n)
                    n = {33'd0, map_pages[i]};
            end
            map_pages[i] = (n > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
            o = '{STAT_JOINED, 6'(i), map_phys[i], map_virt[i], map_pages[i]};
            return o;
        end
        if (map_used >= ENTRIES) begin
            o = '{STAT_FULL, 6'd0, 64'd0, 64'd0, 32'd0};
            return o;
        end
        map_phys[map_used]  = r.phys;
        map_virt[map_used]  = r.virt;
        map_pages[map_used] = r.pages;
        o = '{STAT_APPEND, 6'(map_used), r.phys, r.virt, r.pages};
        map_used++;
        return o;
    endfunction

    task automatic queue_range(logic [63:0] p, logic [63:0] v, logic [31:0] c);
        range_t r;
        r = '{p, v, c};
        pending_ranges.push_back(r);
        sent_history.push_back(r);
    endtask

    // Random range: mostly near an earlier one with the same page offset.
    task automatic queue_random_range();
        range_t      h;
        logic [63:0] ppn;
        logic [63:0] vpn;
        logic [31:0] c;
        int          span;
        int          k;
        case ($urandom_range(9))
            0: c = $urandom;
            1: c = 32'hFFFF_FFFF - $urandom_range(3);
            2: c = 32'd0;
            default: c = $urandom_range(1, 64);
        endcase
        if (sent_history.size() == 0 || $urandom_range(9) < 3) begin
            queue_range({$urandom, $urandom}, {$urandom, $urandom}, c);
        end
        else begin
            h    = sent_history[$urandom_range(sent_history.size() - 1)];
            span = (h.pages > 32'd200) ? 203 : int'(h.pages) + 3;
            k    = int'($urandom_range(2 * span)) - span;
            ppn  = (h.phys >> PAGE_SHIFT) + 64'(signed'(k));
            vpn  = (h.virt >> PAGE_SHIFT) + 64'(signed'(k));
            queue_range({ppn[51:0], 12'($urandom)}, {vpn[51:0], 12'($urandom)}, c);
        end
    endtask

    // Wait until nothing is queued, offered or outstanding.
    task automatic wait_drained();
        while (pending_ranges.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Clock and reset.
    initial
    begin
        clk   = 1'b0;
        rst_n = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d outcomes outstanding",
                     cycles, expected_outcomes.size());
            $display("[inverse_page_range_map_insert] ERROR");
            $finish;
        end
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready) begin
            if (pending_ranges.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                range_t r;
                r = pending_ranges.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.phys_addr  <= r.phys;
                req_ch.virt_addr  <= r.virt;
                req_ch.page_count <= r.pages;
            end
            else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Predict on every accepted request beat.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready) begin
            range_t r;
            r = '{req_ch.phys_addr, req_ch.virt_addr, req_ch.page_count};
            expected_outcomes.push_back(predict_insert(r));
        end
    end

    // Compare every accepted result beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            outcome_t e;
            if (expected_outcomes.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result beat: status %0d index %0d",
                             rsp_ch.status, rsp_ch.entry_index);
            end
            else begin
                e = expected_outcomes.pop_front();
                checked <= checked + 1;
                if (e.status == STAT_JOINED)
                    joins_seen <= joins_seen + 1;
                if (e.status == STAT_FULL)
                    full_seen <= full_seen + 1;
                if (rsp_ch.status !== e.status || rsp_ch.entry_index !== e.index ||
                    rsp_ch.entry_phys !== e.phys || rsp_ch.entry_virt !== e.virt ||
                    rsp_ch.entry_pages !== e.pages) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("Mismatch on result %0d:", checked);
                        $display("  expected st %0d idx %0d phys %h virt %h pages %h",
                                 e.status, e.index, e.phys, e.virt, e.pages);
                        $display("  actual   st %0d idx %0d phys %h virt %h pages %h",
                                 rsp_ch.status, rsp_ch.entry_index, rsp_ch.entry_phys,
                                 rsp_ch.entry_virt, rsp_ch.entry_pages);
                    end
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering beats.
    task automatic hold_receiver();
        recv_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 1'b0;
    endtask

    // Stimulus sequence.
    initial
    begin
        int idle_pattern[4][2];
        idle_pattern   = '{'{0, 0}, '{88, 0}, '{0, 88}, '{15, 15}};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first entry, joins above and below, touching, saturation, extremes.
        queue_range(64'h0000_0000_1000_0000, 64'h0000_0000_5000_0000, 32'd4);
        queue_range(64'h0000_0000_1000_4000, 64'h0000_0000_5000_4000, 32'd3);
        queue_range(64'h0000_0000_0FFF_E123, 64'h0000_0000_4FFF_E456, 32'd2);
        queue_range(64'h0000_0000_1000_7000, 64'h0000_0000_5000_7000, 32'd0);
        queue_range(64'h0000_0000_0FFF_D000, 64'h0000_0000_4FFF_D000, 32'd0);
        queue_range(64'h0000_0000_1000_0000, 64'h0000_0000_5000_0000, 32'hFFFF_FFFF);
        queue_range(64'h0000_0000_0FF0_0000, 64'h0000_0000_4FF0_0000, 32'hFFFF_FFFF);
        queue_range(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 32'hFFFF_FFFF);
        queue_range(64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        queue_range(64'h0000_0000_0000_0FFF, 64'hFFFF_FFFF_FFFF_F000, 32'd1);
        queue_range(64'h0000_0000_2000_0000, 64'h0000_0000_2000_0000, 32'd8);
        queue_range(64'h0000_0000_2000_9000, 64'h0000_0000_2000_9000, 32'd1);
        queue_range(64'h0000_0000_2000_8000, 64'h0000_0000_2000_8000, 32'd1);
        queue_range(64'h0000_0000_3000_0000, 64'h0000_0000_7000_0000, 32'd1);
        queue_range(64'h0000_0000_3000_0000, 64'h0000_0000_7000_1000, 32'd1);
        wait_drained();

        // Random phases with different idle patterns.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pattern[ph][0];
            recv_stall_pct = idle_pattern[ph][1];
            repeat (300) queue_random_range();
            if (ph == 0)
                hold_receiver();
            wait_drained();
        end

        // Final phase on a full table, mostly joins and full results.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (235) queue_random_range();
        hold_receiver();
        wait_drained();

        repeat (100) @(posedge clk);
        $display("Checked %0d results: %0d joins, %0d table full, %0d entries in use.",
                 checked, joins_seen, full_seen, map_used);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("[inverse_page_range_map_insert] OK");
        end
        else begin
            $display("%0d mismatches", mismatches);
            $display("[inverse_page_range_map_insert] ERROR");
        end
        $finish;
    end

endmodule
